// ----- sv/dcc_pkg.sv -----
`timescale 1ns / 1ps

package dcc_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDX_FLD_W = 3;
    localparam int unsigned LEN_FLD_W = 4;
    localparam int unsigned PERIOD_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // sizing
    localparam int unsigned DEFAULT_MAX_BYTES = 8;

    // reset values
    localparam logic [PERIOD_W-1:0] RST_SHORT_HALF    = 8'd116;
    localparam logic [PERIOD_W-1:0] RST_LONG_HALF     = 8'd200;
    localparam logic [BYTE_W-1:0]   RST_PREAMBLE_BITS = 8'd16;
    localparam logic [BYTE_W-1:0]   MASK_MSB          = 8'h80;

    // item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HALF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HALF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_BITS = 2'd2;

    typedef enum logic [1:0] {
        FS_PREAMBLE  = 2'd0,
        FS_SEPARATOR = 2'd1,
        FS_SENDBYTE  = 2'd2
    } t_frame;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_FLD_W-1:0] byte_index;
        logic [BYTE_W-1:0]    byte_value;
        logic [LEN_FLD_W-1:0] packet_len;
    } t_item;

    typedef struct packed {
        logic                second_half;
        logic [PERIOD_W-1:0] half_period;
        logic                packet_latched;
    } t_result;

    typedef struct packed {
        logic [PERIOD_W-1:0] short_half;
        logic [PERIOD_W-1:0] long_half;
        logic [BYTE_W-1:0]   preamble_bits;
    } t_cfg;

endpackage

// ----- sv/dcc_item_if.sv -----
`timescale 1ns / 1ps

interface dcc_item_if;
    import dcc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [IDX_FLD_W-1:0] byte_index;
    logic [BYTE_W-1:0]    byte_value;
    logic [LEN_FLD_W-1:0] packet_len;

    modport source (output valid, output cmd, output byte_index, output byte_value,
                    output packet_len, input ready);
    modport sink   (input valid, input cmd, input byte_index, input byte_value,
                    input packet_len, output ready);
endinterface

// ----- sv/dcc_result_if.sv -----
`timescale 1ns / 1ps

interface dcc_result_if;
    import dcc_pkg::*;

    logic                valid;
    logic                ready;
    logic                second_half;
    logic [PERIOD_W-1:0] half_period;
    logic                packet_latched;

    modport source (output valid, output second_half, output half_period,
                    output packet_latched, input ready);
    modport sink   (input valid, input second_half, input half_period,
                    input packet_latched, output ready);
endinterface

// ----- sv/dcc_framer.sv -----
`timescale 1ns / 1ps

module dcc_framer #(
    parameter int unsigned MAX_BYTES = dcc_pkg::DEFAULT_MAX_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  dcc_pkg::t_item    i_item,
    input  dcc_pkg::t_cfg     i_cfg,
    output dcc_pkg::t_result  o_result
);
    import dcc_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_BYTES);

    logic                r_phase;
    logic [PERIOD_W-1:0] r_period;
    t_frame              r_frame;
    logic [BYTE_W-1:0]   r_pre_left;
    logic [BYTE_W-1:0]   r_mask;
    logic [BYTE_W-1:0]   r_shift;
    logic [LEN_W-1:0]    r_send_idx;
    logic [BYTE_W-1:0]   r_active [MAX_BYTES];
    logic [LEN_W-1:0]    r_active_len;
    logic [BYTE_W-1:0]   r_pending [MAX_BYTES];
    logic [LEN_W-1:0]    r_pending_len;

    logic                n_phase;
    logic [PERIOD_W-1:0] n_period;
    t_frame              n_frame;
    logic [BYTE_W-1:0]   n_pre_left;
    logic [BYTE_W-1:0]   n_mask;
    logic [BYTE_W-1:0]   n_shift;
    logic [LEN_W-1:0]    n_send_idx;
    logic                n_latch;
    logic [LEN_W-1:0]    n_pending_len;

    logic                tick;
    logic                wr;
    logic                first_half;
    logic [BYTE_W-1:0]   mask_shr;
    logic [LEN_W-1:0]    send_inc;
    logic [BYTE_W-1:0]   pre_dec;
    logic [MAX_BYTES-1:0] wr_sel;

    assign tick       = i_step && (i_item.cmd == CMD_TICK);
    assign wr         = i_step && (i_item.cmd == CMD_WRITE);
    assign first_half = tick && !r_phase;
    assign mask_shr   = r_mask >> 1;
    assign send_inc   = r_send_idx + LEN_W'(1);
    assign pre_dec    = r_pre_left - BYTE_W'(1);

    // entry select for pending writes, indexes past the buffer hit nothing
    always_comb begin
        for (int e = 0; e < MAX_BYTES; e++) begin
            wr_sel[e] = (32'(i_item.byte_index) == 32'(e));
        end
    end

    // saturate the pending length to the buffer size
    always_comb begin
        if ({1'b0, i_item.packet_len} > (LEN_FLD_W + 1)'(MAX_BYTES)) begin
            n_pending_len = LEN_W'(MAX_BYTES);
        end else begin
            n_pending_len = LEN_W'(i_item.packet_len);
        end
    end

    // framing state, advanced only on first-half ticks
    always_comb begin
        n_frame = r_frame;
        if (first_half) begin
            unique case (r_frame)
                FS_SEPARATOR: n_frame = FS_SENDBYTE;
                FS_SENDBYTE: begin
                    if (mask_shr == '0) begin
                        n_frame = (send_inc >= r_active_len) ? FS_PREAMBLE : FS_SEPARATOR;
                    end
                end
                default: n_frame = (pre_dec == '0) ? FS_SEPARATOR : FS_PREAMBLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_phase    = r_phase;
        n_period   = r_period;
        n_pre_left = r_pre_left;
        n_mask     = r_mask;
        n_shift    = r_shift;
        n_send_idx = r_send_idx;
        n_latch    = 1'b0;
        if (tick) begin
            n_phase = !r_phase;
        end
        if (first_half) begin
            unique case (r_frame)
                FS_SEPARATOR: begin
                    n_period = i_cfg.long_half;
                    n_mask   = MASK_MSB;
                    n_shift  = r_active[r_send_idx[IDX_W-1:0]];
                end
                FS_SENDBYTE: begin
                    n_period = ((r_shift & r_mask) != '0) ? i_cfg.short_half
                                                          : i_cfg.long_half;
                    n_mask   = mask_shr;
                    if (mask_shr == '0) begin
                        n_send_idx = send_inc;
                        if (send_inc >= r_active_len) begin
                            n_pre_left = i_cfg.preamble_bits;
                        end
                    end
                end
                default: begin
                    n_period   = i_cfg.short_half;
                    n_pre_left = pre_dec;
                    if (pre_dec == '0) begin
                        n_send_idx = '0;
                        n_latch    = 1'b1;
                    end
                end
            endcase
        end
        o_result.second_half    = r_phase;
        o_result.half_period    = n_period;
        o_result.packet_latched = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= 1'b0;
            r_period      <= RST_SHORT_HALF;
            r_frame       <= FS_PREAMBLE;
            r_pre_left    <= RST_PREAMBLE_BITS;
            r_mask        <= MASK_MSB;
            r_shift       <= '0;
            r_send_idx    <= '0;
            r_active_len  <= '0;
            r_pending_len <= '0;
            for (int e = 0; e < MAX_BYTES; e++) begin
                r_active[e]  <= '0;
                r_pending[e] <= '0;
            end
        end else begin
            r_phase    <= n_phase;
            r_period   <= n_period;
            r_frame    <= n_frame;
            r_pre_left <= n_pre_left;
            r_mask     <= n_mask;
            r_shift    <= n_shift;
            r_send_idx <= n_send_idx;
            if (n_latch) begin
                r_active_len <= r_pending_len;
                for (int e = 0; e < MAX_BYTES; e++) begin
                    r_active[e] <= r_pending[e];
                end
            end
            if (wr) begin
                r_pending_len <= n_pending_len;
                for (int e = 0; e < MAX_BYTES; e++) begin
                    if (wr_sel[e]) begin
                        r_pending[e] <= i_item.byte_value;
                    end
                end
            end
        end
    end

endmodule

// ----- sv/dcc_packet_signal_generator.sv -----
// timing: a tick transaction is registered in the input stage at acceptance; when
// handed off, the framing logic fills the result register, which holds it until
// drained; while the result register is full and not drained, a tick waits in the input stage
// throughput: one transaction per cycle, writes and ticks alike, while the result
// register can take a tick (else the tick stalls); writes give no result
// reset: synchronous active-low; framing restarts in preamble, buffers cleared
`timescale 1ns / 1ps

module dcc_packet_signal_generator #(
    parameter int unsigned MAX_BYTES = dcc_pkg::DEFAULT_MAX_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dcc_item_if.sink                         i_item,
    dcc_result_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dcc_pkg::BYTE_W-1:0]       i_cfg_data
);
    import dcc_pkg::*;

    // configuration registers
    t_cfg    r_cfg;

    // input stage: holds one accepted transaction
    logic    r_in_valid;
    t_item   r_in;

    // result stage: parts the framer from the downstream handshake
    logic    r_out_valid;
    t_result r_out;

    logic    in_accept;
    logic    out_free;
    logic    s1_go;
    logic    s1_tick;
    t_result fr_result;

    // result register can take a new value when empty or being drained
    assign out_free  = !r_out_valid || o_result.ready;
    // writes never need the result register, ticks do
    assign s1_go     = r_in_valid && ((r_in.cmd == CMD_WRITE) || out_free);
    assign s1_tick   = s1_go && (r_in.cmd == CMD_TICK);
    assign in_accept = i_item.valid && i_item.ready;

    // input stage refills in the same cycle it hands off
    assign i_item.ready = !r_in_valid || s1_go;

    // config writes land directly, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_half    <= RST_SHORT_HALF;
            r_cfg.long_half     <= RST_LONG_HALF;
            r_cfg.preamble_bits <= RST_PREAMBLE_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHORT_HALF:    r_cfg.short_half    <= i_cfg_data;
                CFG_LONG_HALF:     r_cfg.long_half     <= i_cfg_data;
                CFG_PREAMBLE_BITS: r_cfg.preamble_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.cmd        <= i_item.cmd;
            r_in.byte_index <= i_item.byte_index;
            r_in.byte_value <= i_item.byte_value;
            r_in.packet_len <= i_item.packet_len;
        end
    end

    // framing machine and packet buffers, stepped once per handed-off transaction
    dcc_framer #(
        .MAX_BYTES (MAX_BYTES)
    ) u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (fr_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_tick) begin
            r_out <= fr_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.second_half    = r_out.second_half;
    assign o_result.half_period    = r_out.half_period;
    assign o_result.packet_latched = r_out.packet_latched;

    // a tick handed to the framer always shows up as a result next cycle
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_tick |=> r_out_valid)
        else $error("tick transaction produced no result");

    // latching only happens on the first half of a bit
    a_latch_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.second_half |-> !r_out.packet_latched)
        else $error("packet latched on a second-half tick");

    // an empty input stage never stalls the source
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_item.ready)
        else $error("input stalled while empty");

    // a write leaves the result register untouched
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && (r_in.cmd == CMD_WRITE) && !r_out_valid |=> !r_out_valid)
        else $error("write transaction produced a result");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import dcc_pkg::*;

    localparam int unsigned MAX_BYTES = DEFAULT_MAX_BYTES;

    // half-bit predictor of the track signal plus the queue of results still owed
    class dcc_line_model;
        t_cfg                 cfg;
        logic                 phase_hi;
        logic [PERIOD_W-1:0]  period_now;
        t_frame               frame;
        logic [BYTE_W-1:0]    preamble_cnt;
        logic [BYTE_W-1:0]    mask;
        logic [BYTE_W-1:0]    shifter;
        logic [LEN_FLD_W-1:0] send_idx;
        logic [BYTE_W-1:0]    active_buf [MAX_BYTES];
        logic [LEN_FLD_W-1:0] active_len;
        logic [BYTE_W-1:0]    pending_buf [MAX_BYTES];
        logic [LEN_FLD_W-1:0] pending_len;
        t_result              halfbits_due [$];
        int                   mismatches;

        function new();
            mismatches = 0;
            cfg.short_half    = RST_SHORT_HALF;
            cfg.long_half     = RST_LONG_HALF;
            cfg.preamble_bits = RST_PREAMBLE_BITS;
            phase_hi     = 1'b0;
            period_now   = RST_SHORT_HALF;
            frame        = FS_PREAMBLE;
            preamble_cnt = RST_PREAMBLE_BITS;
            mask         = MASK_MSB;
            shifter      = '0;
            send_idx     = '0;
            active_len   = '0;
            pending_len  = '0;
            foreach (active_buf[i]) active_buf[i] = '0;
            foreach (pending_buf[i]) pending_buf[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            case (idx)
                CFG_SHORT_HALF:    cfg.short_half = data;
                CFG_LONG_HALF:     cfg.long_half = data;
                CFG_PREAMBLE_BITS: cfg.preamble_bits = data;
                default: ;
            endcase
        endfunction

        function void apply_item(t_item it);
            t_result r;
            if (it.cmd == CMD_WRITE) begin
                if (it.byte_index < MAX_BYTES)
                    pending_buf[it.byte_index] = it.byte_value;
                pending_len = (it.packet_len > MAX_BYTES) ? LEN_FLD_W'(MAX_BYTES)
                                                          : it.packet_len;
                return;
            end
            r.packet_latched = 1'b0;
            if (phase_hi) begin
                phase_hi      = 1'b0;
                r.second_half = 1'b1;
                r.half_period = period_now;
                halfbits_due.push_back(r);
                return;
            end
            phase_hi = 1'b1;
            case (frame)
                FS_SEPARATOR: begin
                    period_now = cfg.long_half;
                    frame      = FS_SENDBYTE;
                    mask       = MASK_MSB;
                    shifter    = active_buf[send_idx % MAX_BYTES];
                end
                FS_SENDBYTE: begin
                    period_now = ((shifter & mask) != 0) ? cfg.short_half : cfg.long_half;
                    mask = mask >> 1;
                    if (mask == 0) begin
                        send_idx = send_idx + 1'b1;
                        if (send_idx >= active_len) begin
                            frame        = FS_PREAMBLE;
                            preamble_cnt = cfg.preamble_bits;
                        end else begin
                            frame = FS_SEPARATOR;
                        end
                    end
                end
                default: begin
                    period_now   = cfg.short_half;
                    preamble_cnt = preamble_cnt - 1'b1;
                    if (preamble_cnt == 0) begin
                        frame      = FS_SEPARATOR;
                        send_idx   = '0;
                        active_buf = pending_buf;
                        active_len = pending_len;
                        r.packet_latched = 1'b1;
                    end else begin
                        frame = FS_PREAMBLE;
                    end
                end
            endcase
            r.second_half = 1'b0;
            r.half_period = period_now;
            halfbits_due.push_back(r);
        endfunction

        function void check_halfbit(t_result got);
            t_result want;
            if (halfbits_due.size() == 0) begin
                $error("unexpected result: second_half %0d half_period %0d packet_latched %0d",
                       got.second_half, got.half_period, got.packet_latched);
                mismatches++;
                return;
            end
            want = halfbits_due.pop_front();
            if (got.second_half !== want.second_half) begin
                $error("second_half: expected %0d, actual %0d",
                       want.second_half, got.second_half);
                mismatches++;
            end
            if (got.half_period !== want.half_period) begin
                $error("half_period: expected %0d, actual %0d",
                       want.half_period, got.half_period);
                mismatches++;
            end
            if (got.packet_latched !== want.packet_latched) begin
                $error("packet_latched: expected %0d, actual %0d",
                       want.packet_latched, got.packet_latched);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    dcc_item_if   item_if ();
    dcc_result_if result_if ();

    dcc_line_model line_model = new();

    // transactions accepted on the item channel so far
    int n_in = 0;

    always #1 i_clk = ~i_clk;

    dcc_packet_signal_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // stretch of the run where neither side idles
    function automatic bit quiet_window();
        return (n_in >= 700) && (n_in < 850);
    endfunction

    // monitor: both channels sampled at the edge, before any driver update lands
    always @(posedge i_clk) begin
        t_item   acc;
        t_result got;
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                acc.cmd        = item_if.cmd;
                acc.byte_index = item_if.byte_index;
                acc.byte_value = item_if.byte_value;
                acc.packet_len = item_if.packet_len;
                line_model.apply_item(acc);
                n_in++;
            end
            if (result_if.valid && result_if.ready) begin
                got.second_half    = result_if.second_half;
                got.half_period    = result_if.half_period;
                got.packet_latched = result_if.packet_latched;
                line_model.check_halfbit(got);
            end
        end
    end

    // result receiver: random back-pressure, one long hold-off so the block
    // backs up and stalls its input while ticks keep coming
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_in >= 400) begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (quiet_window()) begin
                result_if.ready <= 1'b1;
            end else begin
                result_if.ready <= ($urandom_range(99) >= 19);
            end
        end
    end

    function automatic t_item tick_item();
        t_item t;
        // payload of a tick is don't-care, so keep it random
        t.cmd        = CMD_TICK;
        t.byte_index = IDX_FLD_W'($urandom);
        t.byte_value = BYTE_W'($urandom);
        t.packet_len = LEN_FLD_W'($urandom);
        return t;
    endfunction

    function automatic t_item write_item(int idx, int val, int len);
        t_item w;
        w.cmd        = CMD_WRITE;
        w.byte_index = IDX_FLD_W'(idx);
        w.byte_value = BYTE_W'(val);
        w.packet_len = LEN_FLD_W'(len);
        return w;
    endfunction

    // offer one transaction, returns at the edge where it is taken;
    // valid stays high so the next item can follow back to back, bar a random gap
    task automatic push_item(t_item it);
        if (!quiet_window() && $urandom_range(99) < 19) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.cmd        <= it.cmd;
        item_if.byte_index <= it.byte_index;
        item_if.byte_value <= it.byte_value;
        item_if.packet_len <= it.packet_len;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    // stop offering, let every owed result drain, then wait out a write that may
    // still sit in the pipeline; the first edge lets the
    // monitor note the last accepted transaction before the queue is checked
    task automatic settle();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (line_model.halfbits_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // all three registers, one per cycle; only called while the block is idle
    task automatic load_regs(logic [7:0] sh, logic [7:0] lh, logic [7:0] pb);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SHORT_HALF;
        i_cfg_data <= sh;
        @(posedge i_clk);
        line_model.write_reg(CFG_SHORT_HALF, sh);
        i_cfg_idx  <= CFG_LONG_HALF;
        i_cfg_data <= lh;
        @(posedge i_clk);
        line_model.write_reg(CFG_LONG_HALF, lh);
        i_cfg_idx  <= CFG_PREAMBLE_BITS;
        i_cfg_data <= pb;
        @(posedge i_clk);
        line_model.write_reg(CFG_PREAMBLE_BITS, pb);
        i_cfg_we <= 1'b0;
    endtask

    // mostly whole packets followed by runs of ticks, with stray writes mixed in
    task automatic random_run(int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                len = $urandom_range(0, MAX_BYTES);
                for (int b = 0; b < ((len == 0) ? 1 : len); b++) begin
                    push_item(write_item(b, $urandom, len));
                    sent++;
                end
            end
            if ($urandom_range(99) < 20) begin
                push_item(write_item($urandom_range(0, MAX_BYTES - 1), $urandom,
                                     $urandom_range(0, MAX_BYTES)));
                sent++;
            end
            repeat ($urandom_range(1, 40)) begin
                push_item(tick_item());
                sent++;
            end
        end
    endtask

    initial begin
        item_if.valid      <= 1'b0;
        item_if.cmd        <= CMD_WRITE;
        item_if.byte_index <= '0;
        item_if.byte_value <= '0;
        item_if.packet_len <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SHORT_HALF;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: shortest one-bit, longest zero-bit, one-bit preamble
        settle();
        load_regs(8'd1, 8'd255, 8'd1);
        // extreme indexes and values, full length, then length zero so
        // only byte 0 goes out
        push_item(write_item(MAX_BYTES - 1, 8'h00, MAX_BYTES));
        push_item(write_item(3, 8'hFF, MAX_BYTES));
        push_item(write_item(0, 8'hC3, 0));
        // the reset preamble runs out and latches the packet, then separator
        // and 8 data bits, then the one-bit preamble latches again
        repeat (52) push_item(tick_item());

        // reset values restored
        settle();
        load_regs(RST_SHORT_HALF, RST_LONG_HALF, RST_PREAMBLE_BITS);
        random_run(200);

        // upper extremes, long preamble; the receiver hold-off lands here
        settle();
        load_regs(8'd255, 8'd1, 8'd255);
        random_run(250);

        // random periods with short preambles for many packets per phase
        repeat (3) begin
            settle();
            load_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(1, 4)));
            random_run(200);
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (line_model.mismatches == 0 && line_model.halfbits_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dcc_pkg.sv
sv/dcc_item_if.sv
sv/dcc_result_if.sv
sv/dcc_framer.sv
sv/dcc_packet_signal_generator.sv
tb/tb.sv
